/* rtl/pd_pkg.sv */
// Shared types and constants of the polyline densifier.
package pd_pkg;
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = 33;
    localparam int MAG_W     = 32;
    localparam int SQ_W      = 66;
    localparam int LEN_W     = 33;
    localparam int SPACING_W = 21;
    localparam int GAP_W     = 31;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP     = 1'b1;
    localparam logic [SPACING_W-1:0] SPACING_RST = 21'd1024;
    localparam logic [GAP_W-1:0]     GAP_RST     = 31'd1024;

    // Job handed from the front part to the back part.
    typedef struct packed {
        logic                       seg;      // a segment prev->cur is measured
        logic                       last;     // emit the waypoint itself afterwards
        logic signed [COORD_W-1:0]  px;
        logic signed [COORD_W-1:0]  py;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
    } t_job;

    // One result point.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      run_last;
        logic                      path_end;
        logic                      capped;
    } t_res;
endpackage

/* rtl/pd_front.sv */
// Front part: accepts waypoints, keeps the previous one and queues jobs.
module pd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [31:0]     i_x,
    input  logic [31:0]     i_y,
    input  logic            i_last,
    output logic            o_job_valid,
    input  logic            i_job_ready,
    output pd_pkg::t_job    o_job
);
    import pd_pkg::*;

    // Two-entry queue between front and back.
    t_job r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic signed [COORD_W-1:0] r_px, r_py;
    logic r_have;
    logic w_push, w_pop;
    t_job w_job;

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign w_pop       = o_job_valid && i_job_ready;
    assign o_job       = r_q[r_rp];

    always_comb begin
        w_job.seg  = r_have;
        w_job.last = i_last;
        w_job.px   = r_px;
        w_job.py   = r_py;
        w_job.cx   = i_x;
        w_job.cy   = i_y;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
            r_have <= 1'b0;
            r_px <= '0;
            r_py <= '0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
                r_have <= ~i_last;
                r_px <= i_last ? '0 : i_x;
                r_py <= i_last ? '0 : i_y;
            end
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

/* rtl/pd_back.sv */
// Back part: measures a segment and emits its points one at a time.
module pd_back #(
    parameter int MAX_PER_SEGMENT = 63
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_valid,
    output logic                       o_job_ready,
    input  pd_pkg::t_job               i_job,
    input  logic [pd_pkg::SPACING_W-1:0] i_spacing,
    input  logic [pd_pkg::GAP_W-1:0]   i_gap,
    output logic                       o_valid,
    input  logic                       i_ready,
    output pd_pkg::t_res               o_res
);
    import pd_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;
    localparam logic [3:0] S_SUM   = 4'd2;
    localparam logic [3:0] S_CMP   = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_PT    = 4'd6;
    localparam logic [3:0] S_PDIV  = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;
    localparam logic [3:0] S_MUL   = 4'd10;
    localparam int CNT_W = $clog2(MAX_PER_SEGMENT + 1);
    localparam int NUM_W = 2 * LEN_W + 1;   // 2*j*sp*|d| + len

    logic [3:0] r_st;
    t_job r_job;
    logic signed [DIFF_W-1:0] r_dx, r_dy;
    logic [MAG_W:0] r_ax, r_ay;
    logic [SQ_W-1:0] r_sx, r_sy, r_sum;
    // shared restoring divider / root unit
    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_den;
    logic [LEN_W:0] r_root;
    logic [6:0] r_it;
    logic [LEN_W-1:0] r_len;
    logic [SPACING_W-1:0] r_sp;
    logic [LEN_W-1:0] r_q;
    logic [CNT_W-1:0] r_n, r_j;
    logic r_capped;
    logic r_cnt_ph;
    logic r_axis;
    logic [MAG_W:0] r_ox;
    logic [LEN_W-1:0] r_step;
    logic r_ovalid;
    t_res r_res;
    t_res r_pt;

    logic [NUM_W-1:0] w_trial, w_rem_sh, w_div_sh;
    logic [SQ_W-1:0] w_sq_pair;
    logic [NUM_W-1:0] w_prod;
    logic [MAG_W:0] w_amag;
    logic w_neg;
    logic signed [COORD_W-1:0] w_off_x, w_off_y;
    logic w_slot, w_load;
    t_res w_fin;

    assign o_job_ready = (r_st == S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_res       = r_res;

    assign w_sq_pair = r_sum >> (2 * r_it);
    assign w_rem_sh  = (r_rem << 2) | {{(NUM_W-2){1'b0}}, w_sq_pair[1:0]};
    assign w_trial   = {{(NUM_W-LEN_W-3){1'b0}}, r_root, 2'b01};
    assign w_div_sh  = {r_rem[NUM_W-2:0], r_num[NUM_W-1]};
    assign w_amag    = r_axis ? r_ay : r_ax;
    assign w_neg     = r_axis ? r_dy[DIFF_W-1] : r_dx[DIFF_W-1];
    assign w_prod    = NUM_W'(r_step) * NUM_W'(w_amag);
    assign w_off_x   = r_dx[DIFF_W-1] ? -COORD_W'(r_ox) : COORD_W'(r_ox);
    assign w_off_y   = w_neg ? -COORD_W'(r_q) : COORD_W'(r_q);

    // output register is free, or frees at this edge
    assign w_slot = !r_ovalid || i_ready;
    assign w_load = w_slot && ((r_st == S_EMIT) || (r_st == S_FIN && r_job.last));
    assign w_fin  = '{x: r_job.cx, y: r_job.cy, run_last: 1'b1, path_end: 1'b1,
                      capped: 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
                r_res <= (r_st == S_FIN) ? w_fin : r_pt;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                S_IDLE: if (i_job_valid) begin
                    r_job <= i_job;
                    r_dx <= DIFF_W'(i_job.cx) - DIFF_W'(i_job.px);
                    r_dy <= DIFF_W'(i_job.cy) - DIFF_W'(i_job.py);
                    r_st <= i_job.seg ? S_SQ : S_FIN;
                end
                S_SQ: begin
                    r_ax <= r_dx[DIFF_W-1] ? (MAG_W+1)'(-r_dx) : (MAG_W+1)'(r_dx);
                    r_ay <= r_dy[DIFF_W-1] ? (MAG_W+1)'(-r_dy) : (MAG_W+1)'(r_dy);
                    r_st <= S_SUM;
                end
                S_SUM: begin
                    r_sx <= SQ_W'(r_ax) * SQ_W'(r_ax);
                    r_sy <= SQ_W'(r_ay) * SQ_W'(r_ay);
                    r_st <= S_CMP;
                end
                S_CMP: begin
                    r_sum <= r_sx + r_sy;
                    r_rem <= '0;
                    r_root <= '0;
                    r_it <= 7'd32;
                    r_sp <= (i_spacing == '0) ? SPACING_W'(1) : i_spacing;
                    r_st <= S_SQRT;
                end
                S_SQRT: begin
                    if (w_rem_sh >= w_trial) begin
                        r_rem <= w_rem_sh - w_trial;
                        r_root <= {r_root[LEN_W-1:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_sh;
                        r_root <= {r_root[LEN_W-1:0], 1'b0};
                    end
                    if (r_it == 7'd0) r_st <= S_DIV;
                    else r_it <= r_it - 7'd1;
                end
                S_DIV: begin
                    r_len <= r_root[LEN_W-1:0];
                    r_j <= '0;
                    r_axis <= 1'b0;
                    if (r_root[LEN_W-1:0] < LEN_W'(i_gap)) begin
                        // short segment: emit its start point only
                        r_pt.x <= r_job.px;
                        r_pt.y <= r_job.py;
                        r_pt.run_last <= ~r_job.last;
                        r_pt.path_end <= 1'b0;
                        r_pt.capped <= 1'b0;
                        r_n <= '0;
                        r_st <= S_EMIT;
                    end else begin
                        // count = len / sp, bit-serial
                        r_num <= {r_root[LEN_W-1:0], {(NUM_W-LEN_W){1'b0}}};
                        r_den <= NUM_W'(r_sp);
                        r_rem <= '0;
                        r_q <= '0;
                        r_it <= 7'(LEN_W);
                        r_cnt_ph <= 1'b1;
                        r_st <= S_PDIV;
                    end
                end
                S_PDIV: begin
                    if (r_it != 7'd0) begin
                        if (w_div_sh >= r_den) begin
                            r_rem <= w_div_sh - r_den;
                            r_q <= {r_q[LEN_W-2:0], 1'b1};
                        end else begin
                            r_rem <= w_div_sh;
                            r_q <= {r_q[LEN_W-2:0], 1'b0};
                        end
                        r_num <= r_num << 1;
                        r_it <= r_it - 7'd1;
                    end else if (r_cnt_ph) begin
                        // count known: saturate it
                        r_cnt_ph <= 1'b0;
                        if (r_q > LEN_W'(MAX_PER_SEGMENT)) begin
                            r_n <= CNT_W'(MAX_PER_SEGMENT);
                            r_capped <= 1'b1;
                        end else begin
                            r_n <= r_q[CNT_W-1:0];
                            r_capped <= 1'b0;
                        end
                        r_st <= (r_q == '0) ? S_FIN : S_PT;
                    end else if (!r_axis) begin
                        r_ox <= (MAG_W+1)'(r_q);
                        r_axis <= 1'b1;
                        r_st <= S_MUL;
                    end else begin
                        r_pt.x <= r_job.px + w_off_x;
                        r_pt.y <= r_job.py + w_off_y;
                        r_pt.path_end <= 1'b0;
                        r_pt.capped <= r_capped;
                        r_pt.run_last <= (r_j == r_n - CNT_W'(1)) && !r_job.last;
                        r_axis <= 1'b0;
                        r_st <= S_EMIT;
                    end
                end
                S_PT: begin
                    r_step <= LEN_W'(LEN_W'(r_j) * LEN_W'(r_sp));
                    r_st <= S_MUL;
                end
                S_MUL: begin
                    // round(step*|d| / len) = (2m+len) / (2len)
                    r_num <= (w_prod << 1) + NUM_W'(r_len);
                    r_den <= NUM_W'(r_len) << 1;
                    r_rem <= '0;
                    r_q <= '0;
                    r_it <= 7'(NUM_W);
                    r_st <= S_PDIV;
                end
                S_EMIT: if (w_slot) begin
                    if (r_n == '0 || r_j == r_n - CNT_W'(1)) begin
                        r_st <= r_job.last ? S_FIN : S_IDLE;
                    end else begin
                        r_j <= r_j + CNT_W'(1);
                        r_st <= S_PT;
                    end
                end
                S_FIN: begin
                    if (!r_job.last) begin
                        r_st <= S_IDLE;
                    end else if (w_slot) begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/polyline_densifier.sv */
// Top level of the polyline densifier.
// Waypoints enter as signed (x,y) with 10 fraction bits; each one after the
// first of a path measures the segment from the previous waypoint with a
// bit-serial square root, divides its length by the spacing and emits the
// points along it (only its start point if it is shorter than the gap), each
// point taking one 67-step bit-serial rounding division per axis. A segment
// is capped at 63 points; the shared serial divide/root unit in the back part
// sets the rate. A two-entry queue lets waypoints be taken while the back part
// works, and a registered output lets the next point be formed while one waits.
module polyline_densifier #(
    parameter int MAX_PER_SEGMENT = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // point_x [31:0], point_y [63:32]
    input  logic        s_axis_tlast,   // path_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // out_x [31:0], out_y [63:32]
    output logic        m_axis_tlast,   // run_last
    output logic [1:0]  m_axis_tuser,   // path_end [0], count_capped [1]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [pd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import pd_pkg::*;

    logic [SPACING_W-1:0] r_spacing;
    logic [GAP_W-1:0]     r_gap;
    logic w_job_valid, w_job_ready;
    t_job w_job;
    t_res w_res;

    assign o_cfg_ready = 1'b1;

    // Hold the two registers; take a write whenever it is offered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= SPACING_RST;
            r_gap <= GAP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SPACING: r_spacing <= i_cfg_data[SPACING_W-1:0];
                CFG_GAP:     r_gap <= i_cfg_data[GAP_W-1:0];
                default:     r_gap <= r_gap;
            endcase
        end
    end

    pd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_x         (s_axis_tdata[31:0]),
        .i_y         (s_axis_tdata[63:32]),
        .i_last      (s_axis_tlast),
        .o_job_valid (w_job_valid),
        .i_job_ready (w_job_ready),
        .o_job       (w_job)
    );

    pd_back #(.MAX_PER_SEGMENT(MAX_PER_SEGMENT)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .o_job_ready (w_job_ready),
        .i_job       (w_job),
        .i_spacing   (r_spacing),
        .i_gap       (r_gap),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_res       (w_res)
    );

    assign m_axis_tdata = {w_res.y, w_res.x};
    assign m_axis_tlast = w_res.run_last;
    assign m_axis_tuser = {w_res.capped, w_res.path_end};
endmodule

/* tb/sv/pd_checker.sv */
// Checker of the polyline densifier: predicts emitted points and compares transfers.
`timescale 1ns / 100ps
module pd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_in_data,   // point_x [31:0], point_y [63:32]
    input  logic        i_in_last,   // path_last
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [63:0] i_out_data,  // out_x [31:0], out_y [63:32]
    input  logic        i_out_last,  // run_last
    input  logic [1:0]  i_out_user,  // path_end [0], count_capped [1]
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [pd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    import pd_pkg::*;

    localparam int MAX_PER_SEGMENT = 63;

    logic [SPACING_W-1:0]      spacing;
    logic [GAP_W-1:0]          gap;
    logic signed [COORD_W-1:0] prev_x, prev_y;
    logic                      have_prev;
    t_res                      point_q[$];
    int                        mismatches;

    function automatic void queue_point(t_res p);
        point_q = {point_q, p};
    endfunction

    function automatic longint rounded_offset(logic [32:0] step, longint d, logic [32:0] len);
        logic [95:0] m, q, l96;
        l96 = 96'(len);
        m = 96'(step) * 96'(d < 0 ? -d : d);
        q = (96'd2 * m + l96) / (96'd2 * l96);
        return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    task automatic predict_points(logic signed [31:0] cx, logic signed [31:0] cy, logic last);
        longint      dx, dy;
        logic [65:0] ax, ay, sq;
        logic [32:0] len, trial, sp, step;
        int          n;
        logic        capped;
        t_res        r;
        int          first;
        first = point_q.size();
        if (have_prev) begin
            dx = longint'(cx) - longint'(prev_x);
            dy = longint'(cy) - longint'(prev_y);
            ax = 66'(dx < 0 ? -dx : dx);
            ay = 66'(dy < 0 ? -dy : dy);
            sq = ax * ax + ay * ay;
            len = '0;
            for (int b = 32; b >= 0; b--) begin
                trial = len | (33'd1 << b);
                if ({33'd0, trial} * {33'd0, trial} <= sq) len = trial;
            end
            if (len >= 33'(gap)) begin
                // zero spacing behaves as one
                sp = (spacing == 0) ? 33'd1 : 33'(spacing);
                capped = (len / sp) > MAX_PER_SEGMENT;
                n = capped ? MAX_PER_SEGMENT : int'(len / sp);
                for (int j = 0; j < n; j++) begin
                    step = 33'(j) * sp;
                    r.x = 32'(longint'(prev_x) + rounded_offset(step, dx, len));
                    r.y = 32'(longint'(prev_y) + rounded_offset(step, dy, len));
                    r.run_last = 1'b0;
                    r.path_end = 1'b0;
                    r.capped = capped;
                    queue_point(r);
                end
            end else begin
                r = '{x: prev_x, y: prev_y, run_last: 1'b0, path_end: 1'b0, capped: 1'b0};
                queue_point(r);
            end
        end
        if (last) begin
            r = '{x: cx, y: cy, run_last: 1'b0, path_end: 1'b1, capped: 1'b0};
            queue_point(r);
            have_prev = 1'b0;
            prev_x = '0;
            prev_y = '0;
        end else begin
            prev_x = cx;
            prev_y = cy;
            have_prev = 1'b1;
        end
        // mark the final point of this waypoint's run
        if (point_q.size() > first) point_q[point_q.size()-1].run_last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_res got, want;
        if (!i_rst_n) begin
            spacing <= SPACING_RST;
            gap <= GAP_RST;
            prev_x = '0;
            prev_y = '0;
            have_prev = 1'b0;
            point_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_SPACING) spacing <= i_cfg_data[SPACING_W-1:0];
                else if (i_cfg_index == CFG_GAP) gap <= i_cfg_data[GAP_W-1:0];
            end
            if (i_out_valid && i_out_ready) begin
                got = '{x: i_out_data[31:0], y: i_out_data[63:32], run_last: i_out_last,
                        path_end: i_out_user[0], capped: i_out_user[1]};
                if (point_q.size() == 0) begin
                    o_errors++;
                    if (mismatches++ < 10)
                        $display("unexpected point x=%0d y=%0d", $signed(got.x), $signed(got.y));
                end else begin
                    want = point_q.pop_front();
                    if (got !== want) begin
                        o_errors++;
                        if (mismatches++ < 10)
                            $display("mismatch exp %0d %0d %b%b%b got %0d %0d %b%b%b",
                                     $signed(want.x), $signed(want.y), want.run_last,
                                     want.path_end, want.capped, $signed(got.x),
                                     $signed(got.y), got.run_last, got.path_end, got.capped);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_points(i_in_data[31:0], i_in_data[63:32], i_in_last);
        end
        o_pending = point_q.size();
    end
endmodule

/* tb/sv/tb.sv */
// Top of the polyline densifier testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb;
    import pd_pkg::*;

    localparam int STALL_LIMIT = 20000;  // cycles without any transfer
    localparam int DRAIN_WAIT  = 200;    // block latency allowance when idle

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid, s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid, m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    int          errors, pending;
    int          tx_idle_pct, rx_idle_pct;
    logic        rx_hold;
    int          cur_spacing;
    int          quiet;

    polyline_densifier u_dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    pd_checker u_checker (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_last(s_axis_tlast),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_last(m_axis_tlast), .i_out_user(m_axis_tuser),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: stall at random, or hold off completely while rx_hold is set.
    always @(negedge i_clk)
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

    // Watchdog: abort when nothing has moved for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet <= 0;
        else if (quiet >= STALL_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else
            quiet <= quiet + 1;
    end

    // Offer one waypoint; returns at the falling edge after its transfer, valid still high.
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Wait for all points to drain, then let the block settle.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_SPACING) cur_spacing = (value[20:0] == 0) ? 1 : int'(value[20:0]);
    endtask

    // Random paths: mostly well-formed walks scaled to the spacing, some noise.
    task automatic random_paths(int items);
        int          sent, hops, span;
        logic [31:0] x, y;
        sent = 0;
        span = (cur_spacing > 2_000_000) ? 2_000_000 : cur_spacing * 9 + 8;
        while (sent < items) begin
            if ($urandom_range(9) == 0) begin
                // noise: isolated points anywhere, possibly long capped hops
                send_point($urandom, $urandom, $urandom_range(1));
                sent++;
            end else begin
                hops = $urandom_range(1, 7);
                x = $urandom;
                y = $urandom;
                for (int h = 0; h <= hops; h++) begin
                    send_point(x, y, h == hops);
                    sent++;
                    x = x + 32'($urandom_range(2 * span) - span);
                    y = y + 32'($urandom_range(2 * span) - span);
                end
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SPACING;
        i_cfg_data = '0;
        rx_hold = 1'b0;
        cur_spacing = 1024;
        tx_idle_pct = 35;
        rx_idle_pct = 60;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: single point, short segments, capped extremes, negative rounding.
        send_point(32'd0, 32'd0, 1'b1);
        send_point(32'd0, 32'd0, 1'b0);
        send_point(32'd5000, 32'd0, 1'b0);
        send_point(32'd5000, 32'd100, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_point(32'hFFFF_F000, 32'd3333, 1'b0);
        send_point(32'hFFFF_A000, 32'hFFFF_E001, 1'b1);
        drain();

        // Spacing one, gap zero: zero-length segments, dense points.
        tx_idle_pct = 35;
        rx_idle_pct = 60;
        write_reg(CFG_SPACING, 32'd1);
        write_reg(CFG_GAP, 32'd0);
        send_point(32'd77, 32'hFFFF_FF00, 1'b0);
        send_point(32'd77, 32'hFFFF_FF00, 1'b0);
        send_point(32'd60, 32'hFFFF_FF09, 1'b1);
        random_paths(50);
        drain();

        // Zero spacing, then the widest spacing with the largest gap: extreme segments still capped.
        tx_idle_pct = 60;
        rx_idle_pct = 35;
        write_reg(CFG_SPACING, 32'd0);
        send_point(32'd10, 32'd10, 1'b0);
        send_point(32'd20, 32'd15, 1'b1);
        drain();
        write_reg(CFG_SPACING, 32'hFFFF_FFFF);
        write_reg(CFG_GAP, 32'hFFFF_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_point(32'd0, 32'd0, 1'b1);
        drain();

        // Gap below spacing: segments in between emit nothing; long receiver hold-off.
        write_reg(CFG_SPACING, 32'd3000);
        write_reg(CFG_GAP, 32'd500);
        send_point(32'd0, 32'd0, 1'b0);
        send_point(32'd1000, 32'd0, 1'b0);
        send_point(32'd1000, 32'd9000, 1'b1);
        fork
            begin
                rx_hold = 1'b1;
                repeat (3000) @(negedge i_clk);
                rx_hold = 1'b0;
            end
            random_paths(50);
        join
        drain();

        // No idling on either side.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(CFG_SPACING, 32'd700);
        write_reg(CFG_GAP, 32'd5000);
        random_paths(50);
        drain();

        if (errors == 0 && pending == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

/* filelist.f */
rtl/pd_pkg.sv
rtl/pd_front.sv
rtl/pd_back.sv
rtl/polyline_densifier.sv
tb/sv/pd_checker.sv
tb/sv/tb.sv
